### hdl/wsu_pkg.sv
// shared types and constants of the wav sample unpacker
package wsu_pkg;

	// sample formats
	localparam logic [2:0] FMT_PCM8  = 3'd0;
	localparam logic [2:0] FMT_PCM16 = 3'd1;
	localparam logic [2:0] FMT_PCM24 = 3'd2;
	localparam logic [2:0] FMT_PCM32 = 3'd3;
	localparam logic [2:0] FMT_F32   = 3'd4;
	localparam logic [2:0] FMT_F64   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// reset values of the registers
	localparam logic [2:0] FORMAT_RST   = FMT_PCM16;
	localparam logic [4:0] CHANNELS_RST = 5'd1;

	// queue sizes
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// full-scale magnitude for float conversion
	localparam logic signed [15:0] FULL_POS = 16'sd32767;
	localparam logic signed [15:0] FULL_NEG = -16'sd32767;

	// gathered sample on its way to the converter
	typedef struct packed {
		logic [63:0] gather;
		logic [3:0]  chan;
	} sample_rec_t;

	// converted result
	typedef struct packed {
		logic signed [15:0] sample;
		logic [3:0]         chan;
		logic               clamped;
	} result_t;

	// converter write into the result queue
	typedef struct packed {
		logic    vld;
		result_t data;
	} result_wr_t;

endpackage

### hdl/wav_sample_unpack_to_int16.sv
// top level of the wav sample unpacker to signed 16-bit
//
// input side is a queue: a byte request is taken on an edge with push high and
// full low; one raw little-endian sample byte per request, up to one per cycle
// result side is a queue too: while empty is low the oldest result sits on
// sample_out, channel_index and was_clamped; pop high takes it on that edge
// config channel: cfg_valid with cfg_ready (always high), cfg_index picks the
// register (0 sample format, 1 channel count), cfg_data carries the value;
// any write to a known register drops a partial sample and restarts the frame
// path: the sample queue, then the stage 1 decode register, then the result queue
// throughput: one byte per cycle while full is low, set by the front gathering one
// byte per clock and a decode plus shift stage behind it
// front and back are split by a two-entry sample queue; the back only pulls a
// sample when the four-entry result queue has room, so when pop stalls the
// result queue fills, then the sample queue, then full rises
// reset clears all queues and gathering state and loads format pcm16 with one
// channel
module wav_sample_unpack_to_int16 #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     stream_byte,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [15:0]             sample_out,
	output logic [3:0]                     channel_index,
	output logic                           was_clamped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wsu_pkg::*;

	logic                 byte_take;
	logic [2:0]           fmt;
	logic                 rec_push;
	sample_rec_t          rec_in;
	sample_rec_t          rec_out;
	logic                 mid_full;
	logic                 mid_empty;
	logic                 rec_take;
	logic [OUT_CNT_W-1:0] out_count;
	result_wr_t           res_wr;
	result_t              res_out;

	// a byte request is taken whenever the sample queue has space
	assign full      = mid_full;
	assign byte_take = push && !mid_full;

	wsu_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_take  (byte_take),
		.stream_byte(stream_byte),
		.fmt        (fmt),
		.rec_push   (rec_push),
		.rec        (rec_in)
	);

	// gathered samples waiting for conversion
	wsu_fifo #(
		.W    ($bits(sample_rec_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (rec_in),
		.full  (mid_full),
		.pop   (rec_take),
		.rdata (rec_out),
		.empty (mid_empty),
		.count ()
	);

	wsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fmt      (fmt),
		.rec_avail(!mid_empty),
		.rec      (rec_out),
		.rec_take (rec_take),
		.out_count(out_count),
		.res_wr   (res_wr)
	);

	// converted results waiting for the receiver; never overflows since the
	// back end reserves a slot before it pulls a sample
	wsu_fifo #(
		.W    ($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_wr.vld),
		.wdata (res_wr.data),
		.full  (),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty),
		.count (out_count)
	);

	assign sample_out    = res_out.sample;
	assign channel_index = res_out.chan;
	assign was_clamped   = res_out.clamped;

endmodule

### hdl/wsu_fifo.sv
// small register queue with count
module wsu_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [W-1:0]                    wdata,
	output logic                            full,
	input  logic                            pop,
	output logic [W-1:0]                    rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/wsu_front.sv
// byte gathering front end: config registers, byte assembly, channel tracking
module wsu_front #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         byte_take,
	input  logic [7:0]                   stream_byte,
	output logic [2:0]                   fmt,
	output logic                         rec_push,
	output wsu_pkg::sample_rec_t         rec
);
	import wsu_pkg::*;

	localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW = (PW + 1 > 6) ? PW + 1 : 6;

	logic [2:0]    fmt_q;
	logic [4:0]    chans_q;
	logic [63:0]   gather_q;
	logic [2:0]    cnt_q;
	logic [PW-1:0] pos_q;

	logic [3:0]    need;
	logic          done;
	logic [63:0]   gather_nx;
	logic [CW-1:0] eff;
	logic [CW-1:0] pos_inc;
	logic [CW-1:0] pos_ext;
	logic          cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign fmt       = fmt_q;

	always_comb begin
		case (fmt_q)
			FMT_PCM8:  need = 4'd1;
			FMT_PCM16: need = 4'd2;
			FMT_PCM24: need = 4'd3;
			FMT_PCM32: need = 4'd4;
			FMT_F32:   need = 4'd4;
			FMT_F64:   need = 4'd8;
			default:   need = 4'd0;
		endcase
	end

	always_comb begin
		gather_nx = gather_q;
		gather_nx[cnt_q*8 +: 8] = stream_byte;
	end

	// effective channel count, zero taken as one, capped at the maximum
	always_comb begin
		if (chans_q == '0) begin
			eff = CW'(1);
		end else if (CW'(chans_q) > CW'(MAX_CHANNELS)) begin
			eff = CW'(MAX_CHANNELS);
		end else begin
			eff = CW'(chans_q);
		end
	end

	assign pos_ext  = CW'(pos_q);
	assign pos_inc  = pos_ext + 1'b1;
	assign done     = byte_take && (need != '0) && ({1'b0, cnt_q} + 4'd1 >= need);
	assign rec_push = done;
	assign rec.gather = gather_nx;
	assign rec.chan   = pos_ext[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FORMAT_RST;
			chans_q  <= CHANNELS_RST;
			gather_q <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_FORMAT) begin
				fmt_q <= cfg_data[2:0];
			end
			if (cfg_index == REG_CHANNELS) begin
				chans_q <= cfg_data[4:0];
			end
			if (cfg_index == REG_FORMAT || cfg_index == REG_CHANNELS) begin
				gather_q <= '0;
				cnt_q    <= '0;
				pos_q    <= '0;
			end
		end else if (byte_take && need != '0) begin
			if (done) begin
				gather_q <= '0;
				cnt_q    <= '0;
				pos_q    <= (pos_inc >= eff) ? '0 : pos_inc[PW-1:0];
			end else begin
				gather_q <= gather_nx;
				cnt_q    <= cnt_q + 1'b1;
			end
		end
	end

endmodule

### hdl/wsu_back.sv
// conversion back end: decode in stage 1, shift and sign into the result queue
module wsu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    fmt,
	input  logic                          rec_avail,
	input  wsu_pkg::sample_rec_t          rec,
	output logic                          rec_take,
	input  logic [wsu_pkg::OUT_CNT_W-1:0] out_count,
	output wsu_pkg::result_wr_t           res_wr
);
	import wsu_pkg::*;

	logic        vld_s1;
	logic        use_mag_s1;
	logic        neg_s1;
	logic        clamp_s1;
	logic [15:0] direct_s1;
	logic [39:0] prod_s1;
	logic [5:0]  sh_s1;
	logic [3:0]  chan_s1;

	logic        use_mag;
	logic        neg;
	logic        clamp;
	logic [15:0] direct;
	logic [39:0] prod;
	logic [5:0]  sh;

	logic [63:0] g;
	logic [23:0] sum24;
	logic [31:0] sum32;
	logic [7:0]  e8;
	logic [22:0] f23;
	logic [23:0] m24;
	logic [8:0]  s9;
	logic [10:0] e11;
	logic [51:0] f52;
	logic [52:0] m53;
	logic [35:0] hi_p;
	logic [46:0] lo_p;
	logic [10:0] r11;
	logic [39:0] shifted;
	logic [15:0] mag;

	// take a sample only when the result queue has room for it and the one in flight
	assign rec_take = rec_avail &&
		(({1'b0, out_count} + {{OUT_CNT_W{1'b0}}, vld_s1}) < (OUT_CNT_W + 1)'(OUT_DEPTH));

	assign g     = rec.gather;
	assign sum24 = g[23:0] + (g[23] ? 24'd255 : 24'd0);
	assign sum32 = g[31:0] + (g[31] ? 32'h0000_ffff : 32'd0);
	assign e8    = g[30:23];
	assign f23   = g[22:0];
	assign m24   = {(e8 != '0), f23};
	assign s9    = (e8 == '0) ? 9'd149 : (9'd150 - {1'b0, e8});
	assign e11   = g[62:52];
	assign f52   = g[51:0];
	assign m53   = {(e11 != '0), f52};
	// times 32767 as shift and subtract
	assign hi_p  = {m53[52:32], 15'd0} - {15'd0, m53[52:32]};
	assign lo_p  = {m53[31:0], 15'd0} - {15'd0, m53[31:0]};
	assign r11   = (e11 == '0) ? 11'd1042 : (11'd1043 - e11);

	always_comb begin
		use_mag = 1'b0;
		neg     = 1'b0;
		clamp   = 1'b0;
		direct  = '0;
		prod    = '0;
		sh      = '0;
		case (fmt)
			FMT_PCM8:  direct = {~g[7], g[6:0], 8'h00};
			FMT_PCM16: direct = g[15:0];
			FMT_PCM24: direct = sum24[23:8];
			FMT_PCM32: direct = sum32[31:16];
			FMT_F32: begin
				if (e8 == 8'hff && f23 != '0) begin
					clamp  = 1'b1;
					direct = FULL_POS;
				end else if (e8 >= 8'd127) begin
					clamp  = !(e8 == 8'd127 && f23 == '0);
					direct = g[31] ? FULL_NEG : FULL_POS;
				end else begin
					use_mag = 1'b1;
					neg     = g[31];
					prod    = 40'({m24, 15'd0} - {15'd0, m24});
					sh      = (s9 > 9'd63) ? 6'd63 : s9[5:0];
				end
			end
			FMT_F64: begin
				if (e11 == 11'h7ff && f52 != '0) begin
					clamp  = 1'b1;
					direct = FULL_POS;
				end else if (e11 >= 11'd1023) begin
					clamp  = !(e11 == 11'd1023 && f52 == '0);
					direct = g[63] ? FULL_NEG : FULL_POS;
				end else begin
					use_mag = 1'b1;
					neg     = g[63];
					prod    = {4'd0, hi_p} + {25'd0, lo_p[46:32]};
					sh      = (r11 > 11'd63) ? 6'd63 : r11[5:0];
				end
			end
			default: direct = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rec_take;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			use_mag_s1 <= use_mag;
			neg_s1     <= neg;
			clamp_s1   <= clamp;
			direct_s1  <= direct;
			prod_s1    <= prod;
			sh_s1      <= sh;
			chan_s1    <= rec.chan;
		end
	end

	assign shifted = prod_s1 >> sh_s1;
	assign mag     = shifted[15:0];

	always_comb begin
		res_wr.vld          = vld_s1;
		res_wr.data.chan    = chan_s1;
		res_wr.data.clamped = clamp_s1;
		if (use_mag_s1) begin
			res_wr.data.sample = neg_s1 ? -mag : mag;
		end else begin
			res_wr.data.sample = direct_s1;
		end
	end

endmodule

### tb/tb_wav_sample_unpack_to_int16.sv
// testbench of the wav sample unpacker: byte stream driver, sample predictor and result checker
`timescale 1ns / 100ps

module tb_wav_sample_unpack_to_int16;
	import wsu_pkg::*;

	localparam int MAX_CH      = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 30;
	localparam int N_PHASES    = 20;

	// register indexes past the end of the register list, writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// format codes the block does not know, bytes are dropped
	localparam logic [2:0] FMT_UNKNOWN_LO = 3'd6;
	localparam logic [2:0] FMT_UNKNOWN_HI = 3'd7;

	logic                    clk;
	logic                    arst_n      = 1'b0;
	logic                    push        = 1'b0;
	logic                    full;
	logic [7:0]              stream_byte = 8'd0;
	logic                    empty;
	logic                    pop         = 1'b0;
	logic signed [15:0]      sample_out;
	logic [3:0]              channel_index;
	logic                    was_clamped;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index   = '0;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;

	// bytes waiting to be offered, and samples the block still owes us
	logic [7:0] pending[$];
	result_t    expected_samples[$];

	// predictor copy of the registers and the gathering state
	logic [2:0]  cur_format;
	logic [4:0]  cur_channels;
	logic [63:0] gather_acc;
	logic [2:0]  gathered;
	logic [3:0]  chan_pos;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int mismatch_count  = 0;
	int cycle_count     = 0;

	wav_sample_unpack_to_int16 #(
		.MAX_CHANNELS(MAX_CH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.stream_byte  (stream_byte),
		.empty        (empty),
		.pop          (pop),
		.sample_out   (sample_out),
		.channel_index(channel_index),
		.was_clamped  (was_clamped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// bytes that make up one sample of a format, 0 for unknown codes
	function automatic int bytes_of(input logic [2:0] fmt);
		case (fmt)
			FMT_PCM8:         return 1;
			FMT_PCM16:        return 2;
			FMT_PCM24:        return 3;
			FMT_PCM32, FMT_F32: return 4;
			FMT_F64:          return 8;
			default:          return 0;
		endcase
	endfunction

	// ieee float to s16: clamp to [-1,1], exact product with 32767, truncate toward zero
	function automatic logic signed [15:0] decode_float(input bit dbl, input logic [63:0] w,
		output bit cl);
		bit           neg;
		int           e;
		int           emax;
		int           bias;
		int           fw;
		int           sh;
		int           mag;
		logic [127:0] m;
		neg  = dbl ? w[63] : w[31];
		e    = dbl ? int'(w[62:52]) : int'(w[30:23]);
		m    = dbl ? {76'd0, w[51:0]} : {105'd0, w[22:0]};
		emax = dbl ? 2047 : 255;
		bias = dbl ? 1023 : 127;
		fw   = dbl ? 52 : 23;
		cl   = 1'b0;
		// nan goes to plus full scale whatever its sign
		if (e == emax && m != 0) begin
			cl = 1'b1;
			return FULL_POS;
		end
		// magnitude one or more, infinities too; exactly one is not a clamp
		if (e >= bias) begin
			cl = !(e == bias && m == 0);
			return neg ? FULL_NEG : FULL_POS;
		end
		if (e != 0)
			m = m | (128'd1 << fw);
		sh  = (e == 0) ? bias + fw - 1 : bias + fw - e;
		m   = (m * 128'd32767) >> sh;
		mag = int'(m[15:0]);
		return 16'(neg ? -mag : mag);
	endfunction

	function automatic logic signed [15:0] convert_gathered(input logic [2:0] fmt,
		input logic [63:0] g, output bit cl);
		int v;
		cl = 1'b0;
		case (fmt)
			FMT_PCM8:  v = (int'(g[7:0]) - 128) * 256;
			FMT_PCM16: v = int'($signed(g[15:0]));
			FMT_PCM24: v = int'($signed(g[23:0])) / 256;
			FMT_PCM32: v = int'($signed(g[31:0])) / 65536;
			FMT_F32:   return decode_float(1'b0, g, cl);
			default:   return decode_float(1'b1, g, cl);
		endcase
		return 16'(v);
	endfunction

	// takes one accepted byte into the predictor, got is set when a sample completes
	function automatic void unpack_byte(input logic [7:0] b, output bit got, output result_t r);
		int need;
		int eff;
		int next_pos;
		bit cl;
		got  = 1'b0;
		r    = '0;
		need = bytes_of(cur_format);
		if (need == 0)
			return;
		gather_acc = gather_acc | (64'(b) << (8 * int'(gathered)));
		if (int'(gathered) + 1 < need) begin
			gathered = gathered + 3'd1;
			return;
		end
		r.sample  = convert_gathered(cur_format, gather_acc, cl);
		r.chan    = chan_pos;
		r.clamped = cl;
		got       = 1'b1;
		gather_acc = '0;
		gathered   = '0;
		// zero channels acts as one, too many saturates at the maximum
		if (cur_channels == 0)
			eff = 1;
		else if (int'(cur_channels) > MAX_CH)
			eff = MAX_CH;
		else
			eff = int'(cur_channels);
		next_pos = int'(chan_pos) + 1;
		if (next_pos >= eff)
			chan_pos = '0;
		else
			chan_pos = 4'(next_pos);
	endfunction

	// a write to a known register also drops the partial sample and restarts the frame
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_FORMAT:   cur_format   = val[2:0];
			REG_CHANNELS: cur_channels = val[4:0];
			default:      return;
		endcase
		gather_acc = '0;
		gathered   = '0;
		chan_pos   = '0;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch %0d: %s", mismatch_count, msg);
	endtask

	// queue n bytes of a word, least significant first
	task automatic push_le(input logic [63:0] w, input int n);
		for (int k = 0; k < n; k++)
			pending.push_back(w[k*8 +: 8]);
	endtask

	// pcm byte, leaning on the extremes
	function automatic logic [7:0] pcm_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hff;
			2:       return 8'h80;
			3:       return 8'h7f;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// float bit pattern spread over the interesting classes
	function automatic logic [63:0] rand_float(input bit dbl);
		logic        s;
		logic [10:0] e;
		logic [51:0] f;
		int          bias;
		int          emax;
		s    = 1'($urandom_range(1));
		f    = 52'({$urandom, $urandom});
		f    = dbl ? f : {29'd0, f[22:0]};
		bias = dbl ? 1023 : 127;
		emax = dbl ? 2047 : 255;
		case ($urandom_range(9))
			0: begin
				// exactly plus or minus one
				e = 11'(bias);
				f = '0;
			end
			1: begin
				// nan
				e = 11'(emax);
				if (f == 0)
					f = 52'd1;
			end
			2: begin
				// infinity
				e = 11'(emax);
				f = '0;
			end
			3: begin
				e = '0;
				f = '0;
			end
			4:       e = '0;
			5, 6:    e = 11'(bias - int'($urandom_range(20, 1)));
			7:       e = 11'($urandom_range(emax - 1, bias));
			default: e = 11'($urandom_range(emax));
		endcase
		if (dbl)
			return {s, e, f};
		return {32'd0, s, e[7:0], f[22:0]};
	endfunction

	// about budget bytes of whole samples, a stray byte now and then, maybe a partial tail
	task automatic queue_random_samples(input logic [2:0] fmt, input int budget);
		int          need;
		int          n;
		logic [63:0] w;
		need = bytes_of(fmt);
		if (need == 0) begin
			for (int k = 0; k < budget; k++)
				pending.push_back(8'($urandom_range(255)));
			return;
		end
		while (budget > 0) begin
			if ($urandom_range(19) == 0) begin
				// stray byte, shifts the alignment of what follows
				pending.push_back(8'($urandom_range(255)));
				budget--;
			end else begin
				if (fmt == FMT_F32)
					w = rand_float(1'b0);
				else if (fmt == FMT_F64)
					w = rand_float(1'b1);
				else
					for (int k = 0; k < 8; k++)
						w[k*8 +: 8] = pcm_byte();
				push_le(w, need);
				budget -= need;
			end
		end
		// leave part of a sample behind for the next register write to drop
		if (need > 1 && $urandom_range(1) == 1) begin
			n = $urandom_range(need - 1, 1);
			for (int k = 0; k < n; k++)
				pending.push_back(8'($urandom_range(255)));
		end
	endtask

	// wait until every byte is taken and every sample back, then let the pipe settle
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending.size() != 0 || push || expected_samples.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// register write while the block is idle, predictor follows on the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_quiet();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// byte driver: offers the next pending byte, holds it while full is high
	always @(posedge clk) begin : drive_proc
		bit      got;
		result_t r;
		if (arst_n) begin
			if (push && !full) begin
				unpack_byte(stream_byte, got, r);
				if (got)
					expected_samples.push_back(r);
			end
			// current request taken or none offered: pick the next one or idle
			if (!push || !full) begin
				if (pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					push        <= 1'b1;
					stream_byte <= pending.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor: takes a sample on pop with empty low, compares with the oldest one owed
	always @(posedge clk) begin : watch_proc
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("sample %0d chan %0d with none expected",
						sample_out, channel_index));
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want.sample)
						report_mismatch($sformatf("sample_out %0d, expected %0d",
							sample_out, want.sample));
					if (channel_index !== want.chan)
						report_mismatch($sformatf("channel_index %0d, expected %0d",
							channel_index, want.chan));
					if (was_clamped !== want.clamped)
						report_mismatch($sformatf("was_clamped %0b, expected %0b",
							was_clamped, want.clamped));
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stim_proc
		logic [2:0]            fmt;
		logic [CFG_DATA_W-1:0] chans;
		// predictor starts from the reset state: pcm16, one channel
		cur_format   = FORMAT_RST;
		cur_channels = CHANNELS_RST;
		gather_acc   = '0;
		gathered     = '0;
		chan_pos     = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no idling
		// pcm16 out of reset: most negative sample
		push_le(64'h8000, 2);
		// half a sample across writes to spare indexes, which must not realign
		push_le(64'h34, 1);
		write_reg(REG_SPARE_A, 8'hff);
		write_reg(REG_SPARE_B, 8'h5a);
		push_le(64'h12, 1);
		// pcm8 offset form at both ends, 16 channels
		write_reg(REG_FORMAT, {5'd0, FMT_PCM8});
		write_reg(REG_CHANNELS, 8'd16);
		push_le(64'hff00, 2);
		// pcm24 negative, truncates toward zero
		write_reg(REG_FORMAT, {5'd0, FMT_PCM24});
		push_le(64'h8000ff, 3);
		// pcm32 most negative; channel count masked to zero acts as one
		write_reg(REG_FORMAT, {5'd0, FMT_PCM32});
		write_reg(REG_CHANNELS, 8'h20);
		push_le(64'h8000_0000, 4);
		// float32 exactly minus one; channel count 31 saturates
		write_reg(REG_FORMAT, {5'd0, FMT_F32});
		write_reg(REG_CHANNELS, 8'hff);
		push_le(64'hbf80_0000, 4);
		// float64 exactly plus one
		write_reg(REG_FORMAT, {5'd0, FMT_F64});
		push_le(64'h3ff0_0000_0000_0000, 8);
		// unknown format from masked data: byte dropped
		write_reg(REG_FORMAT, {5'h1f, FMT_UNKNOWN_LO});
		push_le(64'ha5, 1);

		// random part: formats cycle, idling mode cycles, channel counts at random
		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 9)
				fmt = FMT_UNKNOWN_LO;
			else if (p == 17)
				fmt = FMT_UNKNOWN_HI;
			else
				fmt = 3'(p % 6);
			case ($urandom_range(5))
				0:       chans = 8'd1;
				1:       chans = 8'd16;
				2:       chans = 8'($urandom_range(255)) & 8'he0;
				3:       chans = (8'($urandom_range(255)) & 8'he0) | 8'd31;
				default: chans = (8'($urandom_range(255)) & 8'he0) | 8'($urandom_range(16, 1));
			endcase
			if ($urandom_range(1) == 1) begin
				write_reg(REG_FORMAT, {5'($urandom_range(31)), fmt});
				write_reg(REG_CHANNELS, chans);
			end else begin
				write_reg(REG_CHANNELS, chans);
				write_reg(REG_FORMAT, {5'($urandom_range(31)), fmt});
			end
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom_range(255)));
			// idling: none, sender only, receiver only, both
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					sender_idle_pct = 47;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 47;
				end
				default: begin
					sender_idle_pct = 26;
					recv_stall_pct  = 26;
				end
			endcase
			queue_random_samples(fmt, (bytes_of(fmt) == 0) ? 12 : 48);
		end

		// drain, then give a stray result time to show up
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		wait_quiet();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### wav_sample_unpack_to_int16.f
hdl/wsu_pkg.sv
hdl/wsu_fifo.sv
hdl/wsu_front.sv
hdl/wsu_back.sv
hdl/wav_sample_unpack_to_int16.sv
tb/tb_wav_sample_unpack_to_int16.sv
